// ----- sv/qrs_pkg.sv -----
`default_nettype none
package qrs_pkg;

   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int ROOT_WIDTH = 40;
   localparam int KIND_WIDTH = 3;

   // b*b - 4*a*c stays below 2^(2*COEF_WIDTH+1) when it is not negative
   localparam int DISC_WIDTH = 2 * COEF_WIDTH + 1;
   localparam int DISC_S_WIDTH = 2 * COEF_WIDTH + 3;
   localparam int RAD_WIDTH  = DISC_WIDTH + 2 * FRAC_BITS;
   localparam int SQ_DIGITS  = (RAD_WIDTH + 1) / 2;
   localparam int REM_WIDTH  = SQ_DIGITS + 1;
   localparam int NB_MAG     = COEF_WIDTH + FRAC_BITS;
   localparam int NUM_WIDTH  = ((NB_MAG > SQ_DIGITS) ? NB_MAG : SQ_DIGITS) + 1;
   localparam int DEN_WIDTH  = COEF_WIDTH + 1;
   localparam int SAT_WIDTH  = (NUM_WIDTH + 1 > ROOT_WIDTH) ? NUM_WIDTH + 1 : ROOT_WIDTH;

   localparam logic signed [SAT_WIDTH-1:0] ROOT_HI =
      SAT_WIDTH'((64'sd1 <<< (ROOT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SAT_WIDTH-1:0] ROOT_LO = -ROOT_HI - 1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NONE_REAL = 3'd0,
      KIND_ONE       = 3'd1,
      KIND_TWO       = 3'd2,
      KIND_ALL       = 3'd3,
      KIND_EMPTY     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [DISC_WIDTH-1:0]    disc;
      logic signed [NUM_WIDTH:0] nb;
      logic signed [DEN_WIDTH:0] den;
      kind_type                 kind;
   } sq_side_type;

   typedef struct packed {
      logic [DEN_WIDTH-1:0] den_abs;
      logic                 neg_p;
      logic                 neg_m;
      kind_type             kind;
   } div_side_type;

   typedef struct packed {
      logic [DEN_WIDTH-1:0] rem;
      logic [NUM_WIDTH-1:0] numq;
   } div_lane_type;

   typedef struct packed {
      kind_type               kind;
      logic [ROOT_WIDTH-1:0]  plus;
      logic [ROOT_WIDTH-1:0]  minus;
   } rsp_word_type;

   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic signed [SAT_WIDTH-1:0] v);
      logic signed [SAT_WIDTH-1:0] r;
      r = v;
      if (v > ROOT_HI) r = ROOT_HI;
      if (v < ROOT_LO) r = ROOT_LO;
      return r[ROOT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/qrs_if.sv -----
`default_nettype none
interface qrs_req_if;
   import qrs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;
   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   import qrs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [KIND_WIDTH-1:0]        root_kind;
   logic signed [ROOT_WIDTH-1:0] root_plus;
   logic signed [ROOT_WIDTH-1:0] root_minus;
   modport source (output valid, root_kind, root_plus, root_minus, input ready);
   modport sink (input valid, root_kind, root_plus, root_minus, output ready);
endinterface
`default_nettype wire

// ----- sv/qrs_sqrt_cell.sv -----
`default_nettype none
module qrs_sqrt_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           valid_in,
   input  wire qrs_pkg::sq_side_type           side_in,
   input  wire logic [qrs_pkg::SQ_DIGITS-1:0]  root_in,
   input  wire logic [qrs_pkg::REM_WIDTH-1:0]  rem_in,
   input  wire logic [1:0]                     pair,
   output logic                                valid_out,
   output qrs_pkg::sq_side_type                side_out,
   output logic [qrs_pkg::SQ_DIGITS-1:0]       root_out,
   output logic [qrs_pkg::REM_WIDTH-1:0]       rem_out
);
   import qrs_pkg::*;

   logic                     valid_ff;
   sq_side_type              side_ff;
   logic [SQ_DIGITS-1:0]     root_ff, root_in_w;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in_w;
   logic [REM_WIDTH+1:0]     rem_sh, trial, diff;
   logic                     ge;

   // one restoring digit: bring down two radicand bits, try 4*root+1
   always_comb begin
      rem_sh    = {rem_in, pair};
      trial     = (REM_WIDTH + 2)'({root_in, 2'b01});
      diff      = rem_sh - trial;
      ge        = rem_sh >= trial;
      rem_in_w  = ge ? diff[REM_WIDTH-1:0] : rem_sh[REM_WIDTH-1:0];
      root_in_w = {root_in[SQ_DIGITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         side_ff <= side_in;
         root_ff <= root_in_w;
         rem_ff  <= rem_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign root_out  = root_ff;
   assign rem_out   = rem_ff;
endmodule
`default_nettype wire

// ----- sv/qrs_div_cell.sv -----
`default_nettype none
module qrs_div_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         valid_in,
   input  wire qrs_pkg::div_side_type        side_in,
   input  wire qrs_pkg::div_lane_type [1:0]  lane_in,
   output logic                              valid_out,
   output qrs_pkg::div_side_type             side_out,
   output qrs_pkg::div_lane_type [1:0]       lane_out
);
   import qrs_pkg::*;

   logic                   valid_ff;
   div_side_type           side_ff;
   div_lane_type [1:0]     lane_ff, lane_in_w;
   logic [DEN_WIDTH:0]     t [2];
   logic [DEN_WIDTH:0]     d [2];
   logic [DEN_WIDTH:0]     den_ext;
   logic                   ge [2];

   // one quotient bit per lane; quotient bits shift in where numerator bits leave
   always_comb begin
      den_ext = (DEN_WIDTH + 1)'(side_in.den_abs);
      for (int k = 0; k < 2; k++) begin
         t[k]  = {lane_in[k].rem, lane_in[k].numq[NUM_WIDTH-1]};
         d[k]  = t[k] - den_ext;
         ge[k] = t[k] >= den_ext;
         lane_in_w[k].rem  = ge[k] ? d[k][DEN_WIDTH-1:0] : t[k][DEN_WIDTH-1:0];
         lane_in_w[k].numq = {lane_in[k].numq[NUM_WIDTH-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         side_ff <= side_in;
         lane_ff <= lane_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign lane_out  = lane_ff;
endmodule
`default_nettype wire

// ----- sv/quadratic_root_solver_top.sv -----
`default_nettype none
// Quadratic root solver: each word on req_ch carries signed coefficients a, b, c of
// a*x^2 + b*x + c = 0, and one word on rsp_ch returns root_kind (0 no real roots,
// 1 one root, 2 two roots, 3 every x, 4 no solution) with the roots in signed
// Q23.16, truncated toward zero; unused root fields read 0. A new word is taken
// every cycle while the skid entry is empty. The pipe is 3 front stages (register,
// multiply, discriminant), then one cell per square-root digit (33), one
// operand-prep stage, one cell per quotient bit (34, both roots in parallel
// lanes), then the output register: 72 register stages, the first loaded at the
// accepting edge. The two cell chains advance together with the rest of the
// pipe, one stage per cycle while the pipe is not held; the whole pipe holds
// while the output register and its skid entry are both full, which keeps
// req_ch.ready low until a pop drains the skid entry. A zero quadratic term falls
// back to the linear rule -c/b.
module quadratic_root_solver_top (
   input  wire logic clock,
   input  wire logic reset,
   qrs_req_if.sink   req_ch,
   qrs_rsp_if.source rsp_ch
);
   import qrs_pkg::*;

   logic adv;

   // ---- output register with one skid entry ----
   logic         out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   rsp_word_type out_ff, out_in, skid_ff, skid_in;
   logic         pop, push;

   // ---- front: register coefficients ----
   logic                           s1_v_ff;
   logic signed [COEF_WIDTH-1:0]   a1_ff, b1_ff, c1_ff;
   // ---- multiply ----
   logic                           s2_v_ff;
   logic signed [2*COEF_WIDTH-1:0] bsq2_ff, ac2_ff;
   logic signed [COEF_WIDTH-1:0]   a2_ff, b2_ff, c2_ff;
   // ---- discriminant and classification ----
   logic signed [DISC_S_WIDTH-1:0] disc_full;
   sq_side_type                    sq_side_in;

   logic                  sq_v    [SQ_DIGITS+1];
   sq_side_type           sq_side [SQ_DIGITS+1];
   logic [SQ_DIGITS-1:0]  sq_root [SQ_DIGITS+1];
   logic [REM_WIDTH-1:0]  sq_rem  [SQ_DIGITS+1];
   logic [2*SQ_DIGITS-1:0] rad    [SQ_DIGITS];

   logic                  dv_v    [NUM_WIDTH+1];
   div_side_type          dv_side [NUM_WIDTH+1];
   div_lane_type [1:0]    dv_lane [NUM_WIDTH+1];

   // hold the whole pipe only while the skid entry is occupied
   assign adv          = !skid_v_ff;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         a1_ff   <= req_ch.coef_a;
         b1_ff   <= req_ch.coef_b;
         c1_ff   <= req_ch.coef_c;
         bsq2_ff <= b1_ff * b1_ff;
         ac2_ff  <= a1_ff * c1_ff;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
      end
   end

   // classify; feed the square root a zero radicand unless there are two roots
   always_comb begin
      disc_full = DISC_S_WIDTH'(bsq2_ff) - (DISC_S_WIDTH'(ac2_ff) <<< 2);
      sq_side_in.disc = '0;
      if (a2_ff == '0) begin
         sq_side_in.nb  = -((NUM_WIDTH + 1)'(c2_ff) <<< FRAC_BITS);
         sq_side_in.den = (DEN_WIDTH + 1)'(b2_ff);
         if (b2_ff != '0) begin
            sq_side_in.kind = KIND_ONE;
         end else if (c2_ff == '0) begin
            sq_side_in.kind = KIND_ALL;
         end else begin
            sq_side_in.kind = KIND_EMPTY;
         end
      end else begin
         sq_side_in.nb  = -((NUM_WIDTH + 1)'(b2_ff) <<< FRAC_BITS);
         sq_side_in.den = (DEN_WIDTH + 1)'(a2_ff) <<< 1;
         if (disc_full < 0) begin
            sq_side_in.kind = KIND_NONE_REAL;
         end else if (disc_full == '0) begin
            sq_side_in.kind = KIND_ONE;
         end else begin
            sq_side_in.kind = KIND_TWO;
            sq_side_in.disc = disc_full[DISC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v[0] <= 1'b0;
      end else if (adv) begin
         sq_v[0] <= s2_v_ff;
      end
      if (adv) begin
         sq_side[0] <= sq_side_in;
      end
   end

   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;

   // square-root chain: cell i takes radicand bit pair i counted from the top
   for (genvar i = 0; i < SQ_DIGITS; i++) begin : g_sqrt
      assign rad[i] = (2 * SQ_DIGITS)'(sq_side[i].disc) << (2 * FRAC_BITS);
      qrs_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .valid_in  (sq_v[i]),
         .side_in   (sq_side[i]),
         .root_in   (sq_root[i]),
         .rem_in    (sq_rem[i]),
         .pair      (rad[i][2*(SQ_DIGITS-1-i) +: 2]),
         .valid_out (sq_v[i+1]),
         .side_out  (sq_side[i+1]),
         .root_out  (sq_root[i+1]),
         .rem_out   (sq_rem[i+1])
      );
   end

   // ---- operand prep: nb +/- root (nb = -b*2^F, or -c*2^F if a = 0), sign/magnitude ----
   logic signed [NUM_WIDTH:0] root_s, num_p, num_m, mag_p, mag_m;
   logic signed [DEN_WIDTH:0] den_mag;
   div_side_type              dv_side_in;
   div_lane_type [1:0]        dv_lane_in;

   always_comb begin
      root_s  = (NUM_WIDTH + 1)'({1'b0, sq_root[SQ_DIGITS]});
      num_p   = sq_side[SQ_DIGITS].nb + root_s;
      num_m   = sq_side[SQ_DIGITS].nb - root_s;
      mag_p   = num_p[NUM_WIDTH] ? -num_p : num_p;
      mag_m   = num_m[NUM_WIDTH] ? -num_m : num_m;
      den_mag = sq_side[SQ_DIGITS].den[DEN_WIDTH] ? -sq_side[SQ_DIGITS].den
                                                  : sq_side[SQ_DIGITS].den;
      dv_side_in.den_abs = den_mag[DEN_WIDTH-1:0];
      dv_side_in.neg_p   = num_p[NUM_WIDTH] ^ sq_side[SQ_DIGITS].den[DEN_WIDTH];
      dv_side_in.neg_m   = num_m[NUM_WIDTH] ^ sq_side[SQ_DIGITS].den[DEN_WIDTH];
      dv_side_in.kind    = sq_side[SQ_DIGITS].kind;
      dv_lane_in[0].rem  = '0;
      dv_lane_in[0].numq = mag_p[NUM_WIDTH-1:0];
      dv_lane_in[1].rem  = '0;
      dv_lane_in[1].numq = mag_m[NUM_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v[0] <= 1'b0;
      end else if (adv) begin
         dv_v[0] <= sq_v[SQ_DIGITS];
      end
      if (adv) begin
         dv_side[0] <= dv_side_in;
         dv_lane[0] <= dv_lane_in;
      end
   end

   // divider chain: one quotient bit per cell, plus and minus lanes side by side
   for (genvar j = 0; j < NUM_WIDTH; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .valid_in  (dv_v[j]),
         .side_in   (dv_side[j]),
         .lane_in   (dv_lane[j]),
         .valid_out (dv_v[j+1]),
         .side_out  (dv_side[j+1]),
         .lane_out  (dv_lane[j+1])
      );
   end

   // ---- tail: restore sign, saturate, zero unused roots ----
   logic signed [SAT_WIDTH-1:0] q_p, q_m;
   rsp_word_type                tail_word;
   logic                        tail_v;

   always_comb begin
      q_p = SAT_WIDTH'(dv_lane[NUM_WIDTH][0].numq);
      q_m = SAT_WIDTH'(dv_lane[NUM_WIDTH][1].numq);
      if (dv_side[NUM_WIDTH].neg_p) q_p = -q_p;
      if (dv_side[NUM_WIDTH].neg_m) q_m = -q_m;
      tail_word.kind  = dv_side[NUM_WIDTH].kind;
      tail_word.plus  = '0;
      tail_word.minus = '0;
      case (dv_side[NUM_WIDTH].kind)
         KIND_ONE: begin
            tail_word.plus  = sat_root(q_p);
            tail_word.minus = sat_root(q_p);
         end
         KIND_TWO: begin
            tail_word.plus  = sat_root(q_p);
            tail_word.minus = sat_root(q_m);
         end
         default: begin
            tail_word.plus  = '0;
            tail_word.minus = '0;
         end
      endcase
      tail_v = dv_v[NUM_WIDTH];
   end

   always_comb begin
      pop       = out_v_ff && rsp_ch.ready;
      push      = tail_v && adv;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // pipe is held; drain skid into the output register
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_in   = tail_word;
            out_v_in = 1'b1;
         end else begin
            skid_in   = tail_word;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.root_kind  = out_ff.kind;
   assign rsp_ch.root_plus  = out_ff.plus;
   assign rsp_ch.root_minus = out_ff.minus;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry full while output register empty");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ch.ready |=> out_v_ff)
      else $error("output word dropped while stalled");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !(out_ff.kind == KIND_ONE || out_ff.kind == KIND_TWO)
      |-> out_ff.plus == '0 && out_ff.minus == '0)
      else $error("unused root field not zero");

   a_single_equal: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.kind == KIND_ONE |-> out_ff.plus == out_ff.minus)
      else $error("single root fields differ");
`endif
endmodule
`default_nettype wire

// ----- verif/qrs_tb_if.sv -----
`timescale 1ns / 1ps
// Interfaces come from the RTL (sv/qrs_if.sv); this file only groups the
// testbench-side word types shared by the test top.
package qrs_tb_pkg;
   import qrs_pkg::*;

   typedef struct {
      logic signed [COEF_WIDTH-1:0] a;
      logic signed [COEF_WIDTH-1:0] b;
      logic signed [COEF_WIDTH-1:0] c;
   } coef_word_type;

   typedef struct {
      kind_type                     kind;
      logic signed [ROOT_WIDTH-1:0] plus;
      logic signed [ROOT_WIDTH-1:0] minus;
   } roots_word_type;
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import qrs_pkg::*;
   import qrs_tb_pkg::*;

   localparam int LATENCY    = 72;
   localparam int CYCLE_CAP  = 400000;

   logic clock;
   logic reset;

   qrs_req_if req_ch ();
   qrs_rsp_if rsp_ch ();

   quadratic_root_solver_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // expected root words, oldest first
   roots_word_type expected_roots[$];
   int  error_count;
   int  cycle_count;
   bit  hold_rsp;        // long receiver hold-off request
   bit  stall_enable;    // random receiver stalls

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Truncating division toward zero on 64-bit signed values.
   function automatic longint div_trunc(input longint num, input longint den);
      longint q;
      q = num / den;
      return q;
   endfunction

   // Clamp a root to the 40-bit signed range.
   function automatic logic signed [ROOT_WIDTH-1:0] clamp_root(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (ROOT_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[ROOT_WIDTH-1:0];
   endfunction

   // Solve a*x^2 + b*x + c = 0 exactly as the hardware does.
   function automatic roots_word_type solve_roots(input coef_word_type w);
      roots_word_type r;
      longint a, b, c, one, m, nb, den;
      longint unsigned babs, bsq, low, root, rem, trial, um, pair;
      int i;
      a = w.a; b = w.b; c = w.c;
      one = longint'(1) <<< FRAC_BITS;
      r.kind = KIND_NONE_REAL;
      r.plus = '0;
      r.minus = '0;
      if (a == 0) begin
         if (b == 0) begin
            r.kind = (c == 0) ? KIND_ALL : KIND_EMPTY;
         end else begin
            r.kind = KIND_ONE;
            r.plus = clamp_root(div_trunc(-c * one, b));
            r.minus = r.plus;
         end
         return r;
      end
      babs = (b < 0) ? -b : b;
      bsq = babs * babs;
      low = bsq & 3;
      m = longint'(bsq >> 2) - a * c;
      if (m < 0) return r;
      um = m;
      root = 0;
      rem = 0;
      // 32 digits from m, one from the low pair, then the fraction digits
      for (i = 0; i < 33 + FRAC_BITS; i++) begin
         if (i < 32) pair = (um >> (2 * (31 - i))) & 3;
         else if (i == 32) pair = low;
         else pair = 0;
         trial = (root << 2) | 1;
         rem = (rem << 2) | pair;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      nb = -b * one;
      den = 2 * a;
      if (m == 0 && low == 0) begin
         r.kind = KIND_ONE;
         r.plus = clamp_root(div_trunc(nb, den));
         r.minus = r.plus;
      end else begin
         r.kind = KIND_TWO;
         r.plus = clamp_root(div_trunc(nb + longint'(root), den));
         r.minus = clamp_root(div_trunc(nb - longint'(root), den));
      end
      return r;
   endfunction

   // Random gap length: mostly short, now and then long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one word at the falling edge; hold it until accepted.
   task automatic send_coefs(input coef_word_type w, input bit allow_gap);
      int gap;
      gap = allow_gap ? gap_length() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.coef_a <= w.a;
      req_ch.coef_b <= w.b;
      req_ch.coef_c <= w.c;
      // advance to the accepting edge, predicting on the accept
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      expected_roots.push_back(solve_roots(w));
   endtask

   // Drop valid once the stream of a test ends.
   task automatic idle_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (pick < 4) return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      return 16'($urandom());
   endfunction

   task automatic send_abc(input int a, input int b, input int c, input bit allow_gap);
      coef_word_type w;
      w.a = COEF_WIDTH'(a);
      w.b = COEF_WIDTH'(b);
      w.c = COEF_WIDTH'(c);
      send_coefs(w, allow_gap);
   endtask

   // Wait until every expected word is back.
   task automatic drain_roots();
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   // Field extremes, every kind and the linear fallback.
   task automatic test_directed();
      send_abc(1, -3, 2, 0);              // two roots
      send_abc(1, 2, 1, 0);               // double root
      send_abc(1, 0, 1, 0);               // no real roots
      send_abc(0, 0, 0, 0);               // every x
      send_abc(0, 0, 5, 0);               // no solution
      send_abc(0, 3, -7, 0);              // linear rule
      send_abc(0, -32768, 32767, 0);
      send_abc(0, 1, -32768, 0);
      send_abc(-32768, -32768, -32768, 0);
      send_abc(32767, 32767, 32767, 0);
      send_abc(-32768, 0, 32767, 0);      // largest discriminant with b = 0
      send_abc(32767, -32768, -32768, 0);
      send_abc(1, -32768, 0, 0);          // roots 32768 and 0
      send_abc(-1, 32767, 0, 0);
      send_abc(-32768, 32767, 32767, 0);
      send_abc(2, 2, 1, 0);               // negative D
      send_abc(-1, 1, 0, 0);
      send_abc(3, 5, -2, 0);
      send_abc(-1, -1, -1, 0);
      send_abc(0, -1, 0, 0);
      idle_sender();
   endtask

   // Random coefficients with random sender gaps; receiver stalls follow stall_enable.
   task automatic test_random(input int count);
      coef_word_type w;
      for (int i = 0; i < count; i++) begin
         w.a = ($urandom_range(0, 9) == 0) ? 16'sd0 : rand_coef();
         w.b = rand_coef();
         w.c = rand_coef();
         // keep a fair share of perfect squares for double roots
         if ($urandom_range(0, 9) == 0 && w.a != 0) begin
            w.b = COEF_WIDTH'(2 * ($signed(16'($urandom_range(0, 255))) - 16'sd128));
            w.c = COEF_WIDTH'((w.b / 2) * (w.b / 2));
            w.a = 16'sd1;
         end
         send_coefs(w, 1);
      end
      idle_sender();
   endtask

   // Hold the receiver off while the sender keeps offering, filling the pipe.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 120; i++) send_abc(rand_coef(), rand_coef(), rand_coef(), 0);
            idle_sender();
         end
      join
   endtask

   // Receiver: ready driven at the falling edge; random while stall_enable is set, low during reset or hold_rsp.
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else if (!stall_enable) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= (gap_length() == 0);
      end
   end

   // Check each accepted word against the oldest expectation.
   always @(posedge clock) begin
      roots_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_roots.size() == 0) begin
            $error("unexpected word: kind %0d", rsp_ch.root_kind);
            error_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_ch.root_kind !== want.kind) begin
               $error("root_kind: expected %0d actual %0d", want.kind, rsp_ch.root_kind);
               error_count++;
            end
            if (rsp_ch.root_plus !== want.plus) begin
               $error("root_plus: expected %0d actual %0d", want.plus, rsp_ch.root_plus);
               error_count++;
            end
            if (rsp_ch.root_minus !== want.minus) begin
               $error("root_minus: expected %0d actual %0d", want.minus, rsp_ch.root_minus);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      hold_rsp      = 1'b0;
      stall_enable  = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.coef_a = '0;
      req_ch.coef_b = '0;
      req_ch.coef_c = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      drain_roots();              // sender pauses until all words are back
      stall_enable = 1'b1;
      test_random(300);
      test_backpressure();
      test_random(150);
      stall_enable = 1'b0;
      test_random(180);           // stretch with no receiver stalls

      drain_roots();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
